// ----- rtl/group_bitmap_block_allocator_defines.svh -----
// assertion macros for the block allocator
// used by the allocator rtl, depends on nothing
`ifndef GROUP_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define GROUP_BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define GBBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GBBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gbba_pkg.sv -----
// types and constants of the block group bitmap allocator
// no dependencies
package gbba_pkg;

  localparam int MaxGroupBlocks = 8192;
  localparam int MaxGroups      = 16;
  localparam int WordBits       = 64;
  localparam int WordsPerGroup  = MaxGroupBlocks / WordBits;
  localparam int BitmapWords    = MaxGroups * WordsPerGroup;
  localparam int GrpW           = $clog2(MaxGroups);
  localparam int WidxW          = $clog2(WordsPerGroup);
  localparam int BitW           = $clog2(WordBits);
  localparam int AddrW          = GrpW + WidxW;

  localparam logic [1:0] OP_LOAD_WORD  = 2'd0;
  localparam logic [1:0] OP_LOAD_DESC  = 2'd1;
  localparam logic [1:0] OP_ALLOC      = 2'd2;
  localparam logic [1:0] OP_SET_FREE   = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_SPACE    = 3'd1;
  localparam logic [2:0] ST_BAD_GROUP   = 3'd2;
  localparam logic [2:0] ST_SYSTEM_ZONE = 3'd3;
  localparam logic [2:0] ST_BEYOND_END  = 3'd4;

  localparam logic [2:0] REG_FIRST_DATA  = 3'd0;
  localparam logic [2:0] REG_TOTAL       = 3'd1;
  localparam logic [2:0] REG_GROUP_SIZE  = 3'd2;
  localparam logic [2:0] REG_GROUP_COUNT = 3'd3;
  localparam logic [2:0] REG_RESERVED    = 3'd4;
  localparam logic [2:0] REG_ITABLE_LEN  = 3'd5;

  localparam logic [13:0] GFREE_MAX = 14'd16383;

  typedef logic [WordBits-1:0] word_t;

  typedef struct packed {
    logic        done;
    logic [17:0] quotient;
    logic [13:0] remainder;
  } div_res_t;

endpackage

// ----- rtl/gbba_if.sv -----
// request, result and configuration channels of the allocator
// depends on gbba_pkg
interface gbba_req_if import gbba_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [10:0] index;
  logic [63:0] bitmap_word;
  logic [17:0] free_count;
  logic [17:0] block_bitmap_at;
  logic [17:0] inode_bitmap_at;
  logic [17:0] inode_table_at;
  logic [31:0] goal;
  logic        privileged;
  modport source (output valid, op, index, bitmap_word, free_count, block_bitmap_at,
                  inode_bitmap_at, inode_table_at, goal, privileged, input ready);
  modport sink (input valid, op, index, bitmap_word, free_count, block_bitmap_at,
                inode_bitmap_at, inode_table_at, goal, privileged, output ready);
endinterface

interface gbba_res_if;
  logic        valid;
  logic        ready;
  logic [17:0] block;
  logic        granted;
  logic [2:0]  status;
  modport source (output valid, block, granted, status, input ready);
  modport sink (input valid, block, granted, status, output ready);
endinterface

interface gbba_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [17:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/group_bitmap_block_allocator.sv -----
// Block group bitmap allocator. Load requests (bitmap word, group descriptor,
// volume free counter) take effect on acceptance and give their result from the
// done state. An allocate request runs the divider to split the goal into
// group and offset, then scans the group's bitmap one 64-bit word at a time
// (a read of the bitmap memory, then an examine/write-back of that word).
// One request is worked on at a time; a new one is taken while a result waits.
// depends on gbba_pkg, gbba_if, gbba_div, gbba_ram and the defines header
`include "group_bitmap_block_allocator_defines.svh"

module group_bitmap_block_allocator import gbba_pkg::*; (
  input logic         clk,
  input logic         rst,
  gbba_req_if.sink    req,
  gbba_res_if.source  res,
  gbba_cfg_if.sink    cfg
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EXAM = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // configuration
  logic        first_data_block;
  logic [17:0] total_blocks;
  logic [13:0] group_size;
  logic [4:0]  group_count;
  logic [17:0] reserved_blocks;
  logic [13:0] inode_table_blocks;

  // group descriptors and counters
  logic [13:0] group_free [MaxGroups];
  logic [17:0] bb_loc [MaxGroups];
  logic [17:0] ib_loc [MaxGroups];
  logic [17:0] it_loc [MaxGroups];
  logic [17:0] volume_free;

  logic [2:0]  state;
  logic [17:0] goal_c;
  logic [GrpW-1:0]  grp;
  logic [13:0] off;
  logic [13:0] scan_end;
  logic [WidxW-1:0] widx;
  logic [WidxW-1:0] last_w;
  logic [17:0] blk;
  logic [17:0] r_block;
  logic        r_granted;
  logic [2:0]  r_status;

  logic        accept;
  logic [13:0] gs;
  logic [17:0] goal_clamp;
  logic        div_start;
  div_res_t    div_res;
  logic        ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;
  word_t       ram_wdata;
  word_t       ram_q;
  word_t       cand;
  logic [BitW-1:0] lo;
  logic [BitW-1:0] hi;
  logic [BitW-1:0] hit_bit;
  logic        hit;
  logic [13:0] end_m1;
  logic        sys_zone;
  logic [18:0] blk_w;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign gs        = (group_size == 14'd0) ? 14'd1 : group_size;

  // goal clamp into the volume
  assign goal_clamp = (req.goal < {31'd0, first_data_block} ||
                       req.goal >= {14'd0, total_blocks}) ?
                      {17'd0, first_data_block} : req.goal[17:0];
  assign div_start  = accept && (req.op == OP_ALLOC) &&
                      !(({1'b0, volume_free} < {1'b0, reserved_blocks} + 19'd1) &&
                        !req.privileged);

  gbba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (goal_clamp - {17'd0, first_data_block}),
    .divisor  (gs),
    .res      (div_res)
  );

  // scan window of the current word
  assign end_m1 = scan_end - 14'd1;
  assign lo = (widx == off[BitW+WidxW-1:BitW]) ? off[BitW-1:0] : '0;
  assign hi = (widx == last_w) ? end_m1[BitW-1:0] : '1;
  assign cand = ~ram_q & (word_t'('1) << lo) & (word_t'('1) >> (BitW'(WordBits - 1) - hi));

  // lowest clear bit
  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int j = WordBits - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit     = 1'b1;
        hit_bit = BitW'(j);
      end
    end
  end

  // bitmap memory port selection
  assign ram_raddr = {grp, widx};
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req.index;
    ram_wdata = req.bitmap_word;
    if (state == S_EXAM) begin
      ram_we    = hit;
      ram_waddr = {grp, widx};
      ram_wdata = ram_q | (word_t'(1) << hit_bit);
    end else if (accept && req.op == OP_LOAD_WORD) begin
      ram_we = 1'b1;
    end
  end

  gbba_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // system zone test on the found block
  assign blk_w = {1'b0, blk};
  assign sys_zone =
      (blk_w <= {1'b0, bb_loc[grp]} && {1'b0, bb_loc[grp]} <= blk_w + 19'd2) ||
      (blk_w <= {1'b0, ib_loc[grp]} && {1'b0, ib_loc[grp]} <= blk_w + 19'd2) ||
      ({1'b0, it_loc[grp]} <= blk_w &&
       blk_w <= {1'b0, it_loc[grp]} + {5'd0, inode_table_blocks} + 19'd1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      first_data_block   <= 1'b1;
      total_blocks       <= 18'd131073;
      group_size         <= 14'd8192;
      group_count        <= 5'd16;
      reserved_blocks    <= 18'd0;
      inode_table_blocks <= 14'd256;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FIRST_DATA:  first_data_block   <= cfg.data[0];
        REG_TOTAL:       total_blocks       <= cfg.data;
        REG_GROUP_SIZE:  group_size         <= cfg.data[13:0];
        REG_GROUP_COUNT: group_count        <= cfg.data[4:0];
        REG_RESERVED:    reserved_blocks    <= cfg.data;
        REG_ITABLE_LEN:  inode_table_blocks <= cfg.data[13:0];
        default: ;
      endcase
    end
  end

  // sequencer and state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      volume_free <= 18'd0;
      res.valid   <= 1'b0;
      for (int g = 0; g < MaxGroups; g++) begin
        group_free[g] <= '0;
        bb_loc[g]     <= '0;
        ib_loc[g]     <= '0;
        it_loc[g]     <= '0;
      end
    end else begin
      if (res.valid && res.ready && state != S_DONE) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            r_block   <= 18'd0;
            r_granted <= 1'b0;
            r_status  <= ST_OK;
            goal_c    <= goal_clamp;
            state     <= S_DONE;
            case (req.op)
              OP_LOAD_DESC: begin
                if (req.index[10:GrpW] == '0) begin
                  group_free[req.index[GrpW-1:0]] <=
                    (req.free_count > {4'd0, GFREE_MAX}) ? GFREE_MAX : req.free_count[13:0];
                  bb_loc[req.index[GrpW-1:0]] <= req.block_bitmap_at;
                  ib_loc[req.index[GrpW-1:0]] <= req.inode_bitmap_at;
                  it_loc[req.index[GrpW-1:0]] <= req.inode_table_at;
                end
              end
              OP_ALLOC: begin
                if (div_start) begin
                  state <= S_DIV;
                end else begin
                  r_status <= ST_NO_SPACE;
                end
              end
              OP_SET_FREE: volume_free <= req.free_count;
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            off      <= div_res.remainder;
            scan_end <= (gs < 14'(MaxGroupBlocks)) ? gs : 14'(MaxGroupBlocks);
            grp      <= div_res.quotient[GrpW-1:0];
            state    <= S_CHK;
            if (div_res.quotient >= {13'd0, group_count} ||
                div_res.quotient[17:GrpW] != '0) begin
              r_status <= ST_BAD_GROUP;
              state    <= S_DONE;
            end
          end
        end
        S_CHK: begin
          widx   <= off[BitW+WidxW-1:BitW];
          last_w <= end_m1[BitW+WidxW-1:BitW];
          if (group_free[grp] == 14'd0 || off >= scan_end) begin
            r_status <= ST_NO_SPACE;
            state    <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_EXAM;
        S_EXAM: begin
          if (hit) begin
            blk   <= goal_c - {4'd0, off} + {5'd0, widx, hit_bit};
            state <= S_FIN;
          end else if (widx == last_w) begin
            r_status <= ST_NO_SPACE;
            state    <= S_DONE;
          end else begin
            widx  <= widx + WidxW'(1);
            state <= S_RD;
          end
        end
        S_FIN: begin
          state <= S_DONE;
          if (sys_zone) begin
            r_status <= ST_SYSTEM_ZONE;
          end else if (blk >= total_blocks) begin
            r_status <= ST_BEYOND_END;
          end else begin
            r_block         <= blk;
            r_granted       <= 1'b1;
            group_free[grp] <= group_free[grp] - 14'd1;
            if (volume_free != 18'd0) begin
              volume_free <= volume_free - 18'd1;
            end
          end
        end
        S_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid   <= 1'b1;
            res.block   <= r_block;
            res.granted <= r_granted;
            res.status  <= r_status;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GBBA_ASSERT_NOW(a_grant_ok, res.valid && res.granted, res.status == ST_OK, "grant without ok")
  `GBBA_ASSERT_NEXT(a_busy_after_accept, accept, state != S_IDLE, "idle after accept")
  `GBBA_ASSERT_NOW(a_scan_window, state == S_EXAM, widx <= last_w, "scan past group end")
  `GBBA_ASSERT_NOW(a_div_in_div, div_res.done, state == S_DIV, "divider done out of turn")

endmodule

// ----- rtl/gbba_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on gbba_pkg
module gbba_div import gbba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [17:0] dividend,
  input  logic [13:0] divisor,
  output div_res_t    res
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [17:0] quo;
  logic [14:0] rem;
  logic [14:0] trial;
  logic        fits;

  // one shift and trial subtract
  assign trial = {rem[13:0], quo[17]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        quo  <= dividend;
        rem  <= 15'd0;
      end else if (busy) begin
        rem <= fits ? trial - {1'b0, divisor} : trial;
        quo <= {quo[16:0], fits};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd17) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = {done, quo, rem[13:0]};

endmodule

// ----- rtl/gbba_ram.sv -----
// block bitmap store, one write and one registered read port
// depends on gbba_pkg
module gbba_ram import gbba_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  word_t            wdata,
  input  logic [AddrW-1:0] raddr,
  output word_t            rdata
);

  word_t mem [BitmapWords];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
